@@ design/rwtm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwtm_pkg: shared types and constants for the raycast wall texel mapper
// Face and texture codes, register indexes and the side-band structs that
// travel down the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rwtm_pkg;

    // Wall face codes as they arrive with each item.
    localparam logic [2:0] FACE_NORTH   = 3'd0;
    localparam logic [2:0] FACE_SOUTH   = 3'd1;
    localparam logic [2:0] FACE_EAST    = 3'd2;
    localparam logic [2:0] FACE_WEST    = 3'd3;
    localparam logic [2:0] FACE_DOOR_NS = 3'd4;
    localparam logic [2:0] FACE_DOOR_EW = 3'd5;

    localparam logic [2:0] TEX_DOOR = 3'd4;

    // Register indexes (word address of the configuration port).
    localparam logic [1:0] REG_SCREEN_HEIGHT  = 2'd0;
    localparam logic [1:0] REG_TEXTURE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd2;

    localparam logic [11:0] RST_SCREEN_HEIGHT  = 12'd480;
    localparam logic [10:0] RST_TEXTURE_WIDTH  = 11'd64;
    localparam logic [10:0] RST_TEXTURE_HEIGHT = 11'd64;

    localparam logic [9:0]  TEXEL_MAX = 10'd1023;
    localparam logic [10:0] ROW_MAX   = 11'd2047;

    // Angle constants in radians, Q30, for the cosine table build.
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Fixed widths of the back-end arithmetic.
    localparam int OFF_W   = 15;   // whole-row offset above the screen
    localparam int SUM_W   = 16;   // row plus offset
    localparam int PROD2_W = 27;   // (row plus offset) times texture height
    localparam int TR_Q_W  = 10;   // texel row quotient bits

    typedef struct packed {
        logic        fv;      // face code is a real face
        logic [2:0]  sel;
        logic [9:0]  tc;
        logic [11:0] col;
        logic [10:0] row;
    } t_side;

    typedef struct packed {
        t_side       s;
        logic        in_span;
        logic        hfz;     // wall height is zero
        logic        ovf;     // texel row quotient beyond its width
        logic [10:0] sr;
    } t_side2;

endpackage

`default_nettype wire

@@ design/rwtm_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rwtm_div_pipe: pipelined restoring divider
// One quotient bit per register stage, a side-band word travels along.
// The caller guarantees the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwtm_div_pipe
    import rwtm_pkg::*;
#(
    parameter int N_W = 43,
    parameter int D_W = 24,
    parameter int Q_W = 31,
    parameter int S_W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  logic [S_W-1:0] i_side,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quot,
    output logic [S_W-1:0] o_side
);

    logic           c_vld  [Q_W+1];
    logic [D_W-1:0] c_rem  [Q_W+1];
    logic [Q_W-1:0] c_low  [Q_W+1];
    logic [Q_W-1:0] c_quot [Q_W+1];
    logic [D_W-1:0] c_den  [Q_W+1];
    logic [S_W-1:0] c_side [Q_W+1];

    assign c_vld[0]  = i_valid;
    assign c_rem[0]  = D_W'(i_num >> Q_W);
    assign c_low[0]  = i_num[Q_W-1:0];
    assign c_quot[0] = '0;
    assign c_den[0]  = i_den;
    assign c_side[0] = i_side;

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic           r_vld;
        logic [D_W-1:0] r_rem;
        logic [Q_W-1:0] r_low;
        logic [Q_W-1:0] r_quot;
        logic [D_W-1:0] r_den;
        logic [S_W-1:0] r_side;
        logic [D_W:0]   trial;
        logic [D_W:0]   diff;
        logic           ge;
        logic [D_W-1:0] n_rem;

        assign trial = {c_rem[s], c_low[s][Q_W-1]};
        assign diff  = trial - {1'b0, c_den[s]};
        assign ge    = trial >= {1'b0, c_den[s]};
        assign n_rem = ge ? diff[D_W-1:0] : trial[D_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= c_vld[s];
            end
            r_rem  <= n_rem;
            r_low  <= c_low[s] << 1;
            r_quot <= {c_quot[s][Q_W-2:0], ge};
            r_den  <= c_den[s];
            r_side <= c_side[s];
        end

        assign c_vld[s+1]  = r_vld;
        assign c_rem[s+1]  = r_rem;
        assign c_low[s+1]  = r_low;
        assign c_quot[s+1] = r_quot;
        assign c_den[s+1]  = r_den;
        assign c_side[s+1] = r_side;
    end

    assign o_valid = c_vld[Q_W];
    assign o_quot  = c_quot[Q_W];
    assign o_side  = c_side[Q_W];

endmodule

`default_nettype wire

@@ design/rwtm_corr.sv @@
// ----------------------------------------------------------------------------
// rwtm_corr: fisheye correction front end
// Angle difference, cosine ROM lookup, distance times cosine and the lower
// clamp, in four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwtm_corr
    import rwtm_pkg::*;
#(
    parameter int FRAC_BITS         = 16,
    parameter int COS_TABLE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_ray_angle,
    input  logic [15:0] i_player_angle,
    input  logic [23:0] i_dist,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [23:0] o_adj,
    output t_side       o_side
);

    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES);
    localparam logic [23:0] MIN_DIST = 24'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    typedef logic signed [17:0] t_cos_rom [COS_TABLE_ENTRIES];

    // Q16 cosine of entry k, Taylor series in Q30 over the first quadrant.
    function automatic logic signed [17:0] cos_entry(input logic [63:0] k);
        logic [63:0]        th;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic               neg;
        neg = 1'b0;
        th  = (k * TWO_PI_Q30) / COS_TABLE_ENTRIES;
        if (th > PI_Q30) th = TWO_PI_Q30 - th;
        if (th > HALF_PI_Q30) begin
            th  = PI_Q30 - th;
            neg = 1'b1;
        end
        t2   = (th * th) >> 30;
        term = ONE_Q30;
        sum  = $signed(term);
        term = ((term * t2) >> 30) / 64'd2;   sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 64'd12;  sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 64'd30;  sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 64'd56;  sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 64'd90;  sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 64'd132; sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 64'd182; sum = sum - $signed(term);
        if (sum < 0) sum = 0;
        mag = ($unsigned(sum) + 64'd8192) >> 14;
        return neg ? -$signed(18'(mag)) : $signed(18'(mag));
    endfunction

    function automatic t_cos_rom build_rom();
        t_cos_rom rom;
        for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
            rom[k] = cos_entry(64'(k));
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_rom();

    logic [15:0] diff;
    logic [31:0] idx_full;
    assign diff     = i_ray_angle - i_player_angle;
    assign idx_full = 32'(diff) * 32'(COS_TABLE_ENTRIES);

    // Stage 1: table index.
    logic             r1_vld;
    logic [IDX_W-1:0] r1_idx;
    logic [23:0]      r1_dist;
    t_side            r1_side;
    // Stage 2: ROM read.
    logic               r2_vld;
    logic signed [17:0] r2_cos;
    logic [23:0]        r2_dist;
    t_side              r2_side;
    // Stage 3: product.
    logic        r3_vld;
    logic [40:0] r3_prod;
    logic        r3_cpos;
    t_side       r3_side;
    // Stage 4: clamp.
    logic        r4_vld;
    logic [23:0] r4_adj;
    t_side       r4_side;

    logic [24:0] adj_t;
    logic [23:0] n_adj;
    assign adj_t = 25'(r3_prod >> 16);
    assign n_adj = (!r3_cpos || adj_t < 25'(MIN_DIST)) ? MIN_DIST : adj_t[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
        r1_idx  <= IDX_W'(idx_full >> 16);
        r1_dist <= i_dist;
        r1_side <= i_side;
        r2_cos  <= COS_ROM[r1_idx];
        r2_dist <= r1_dist;
        r2_side <= r1_side;
        r3_prod <= 41'(r2_dist) * 41'(r2_cos[16:0]);
        r3_cpos <= r2_cos > 0;
        r3_side <= r2_side;
        r4_adj  <= n_adj;
        r4_side <= r3_side;
    end

    assign o_valid = r4_vld;
    assign o_adj   = r4_adj;
    assign o_side  = r4_side;

endmodule

`default_nettype wire

@@ design/raycast_wall_texel_mapper.sv @@
// ----------------------------------------------------------------------------
// raycast_wall_texel_mapper: per-pixel texture mapping of a raycast wall
// Fisheye-corrected wall height, texel column and row, and display row for
// one screen pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   An item (one pixel of a wall column) is taken at every rising edge with
//   start high and busy low. busy is never raised: the pipeline has no stall,
//   so a new item may enter in every cycle.
//   Each result leaves on the o_ result ports with o_valid high for exactly
//   one cycle; the receiver must take it then, it cannot hold results off.
//   Throughput is one item per cycle. The pipeline is made of the two
//   dividers, one quotient bit per stage: FRAC_BITS + 15 stages for the wall
//   height and 10 for the texel row, plus four front-end stages (index,
//   cosine ROM, multiply, clamp), two back-end stages and the output register.
//   Configuration goes through the APB-style port (screen height at 0x0,
//   texture width at 0x4, texture height at 0x8) while no item is in flight.
//   A synchronous reset empties the pipeline and restores 480/64/64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raycast_wall_texel_mapper
    import rwtm_pkg::*;
#(
    parameter int FRAC_BITS         = 16,
    parameter int COS_TABLE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item channel
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_ray_angle,
    input  logic [15:0] i_player_angle,
    input  logic [23:0] i_ray_distance,
    input  logic [23:0] i_hit_x,
    input  logic [23:0] i_hit_y,
    input  logic [2:0]  i_face,
    input  logic [11:0] i_screen_column,
    input  logic [10:0] i_row,
    // Result channel
    output logic        o_valid,
    output logic        o_in_column,
    output logic [2:0]  o_texture_select,
    output logic [9:0]  o_texel_column,
    output logic [9:0]  o_texel_row,
    output logic [10:0] o_screen_row,
    output logic [11:0] o_dest_column,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Wall height carries FRAC_BITS fraction bits and at most 15 whole bits,
    // since the corrected distance never drops below 0.1.
    localparam int HF_W  = FRAC_BITS + 15;
    localparam int N1_W  = 11 + 2 * FRAC_BITS;
    localparam int D2_W  = HF_W + 1;
    localparam int N2_W  = PROD2_W + FRAC_BITS;
    localparam int TCP_W = FRAC_BITS + 11;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0] r_screen_height;
    logic [10:0] r_texture_width;
    logic [10:0] r_texture_height;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height  <= RST_SCREEN_HEIGHT;
            r_texture_width  <= RST_TEXTURE_WIDTH;
            r_texture_height <= RST_TEXTURE_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SCREEN_HEIGHT:  r_screen_height  <= pwdata[11:0];
                REG_TEXTURE_WIDTH:  r_texture_width  <= pwdata[10:0];
                REG_TEXTURE_HEIGHT: r_texture_height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCREEN_HEIGHT:  prdata = 32'(r_screen_height);
            REG_TEXTURE_WIDTH:  prdata = 32'(r_texture_width);
            REG_TEXTURE_HEIGHT: prdata = 32'(r_texture_height);
            default:            prdata = '0;
        endcase
    end

    logic [10:0] half;
    assign half = r_screen_height[11:1];

    // ------------------------------------------------------------------
    // Input side: texture select and texel column need only the item itself,
    // so they are formed here and ride along as side-band.
    // ------------------------------------------------------------------
    logic             in_acc;
    logic [23:0]      coord;
    logic [TCP_W-1:0] tc_wide;
    logic [10:0]      tc11;
    t_side            in_side;

    assign busy   = 1'b0;
    assign in_acc = start && !busy;

    always_comb begin
        case (i_face) inside
            FACE_NORTH, FACE_SOUTH, FACE_DOOR_NS: coord = i_hit_x;
            default:                              coord = i_hit_y;
        endcase
    end

    assign tc_wide = TCP_W'(coord[FRAC_BITS-1:0]) * TCP_W'(r_texture_width);
    assign tc11    = 11'(tc_wide >> FRAC_BITS);

    always_comb begin
        in_side.fv  = i_face <= FACE_DOOR_EW;
        in_side.sel = (i_face > FACE_DOOR_NS) ? TEX_DOOR : i_face;
        in_side.tc  = (tc11 > 11'(TEXEL_MAX)) ? TEXEL_MAX : tc11[9:0];
        in_side.col = i_screen_column;
        in_side.row = i_row;
    end

    // ------------------------------------------------------------------
    // Front end: corrected distance
    // ------------------------------------------------------------------
    logic        c_vld;
    logic [23:0] c_adj;
    t_side       c_side;

    rwtm_corr #(
        .FRAC_BITS        (FRAC_BITS),
        .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
    ) u_corr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_acc),
        .i_ray_angle   (i_ray_angle),
        .i_player_angle(i_player_angle),
        .i_dist        (i_ray_distance),
        .i_side        (in_side),
        .o_valid       (c_vld),
        .o_adj         (c_adj),
        .o_side        (c_side)
    );

    // ------------------------------------------------------------------
    // Wall height: (half << 2F) / distance
    // ------------------------------------------------------------------
    logic                    d1_vld;
    logic [HF_W-1:0]         d1_hf;
    logic [$bits(t_side)-1:0] d1_side_bits;
    t_side                   d1_side;

    rwtm_div_pipe #(
        .N_W(N1_W),
        .D_W(24),
        .Q_W(HF_W),
        .S_W($bits(t_side))
    ) u_div_height (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(c_vld),
        .i_num  (N1_W'(half) << (2 * FRAC_BITS)),
        .i_den  (c_adj),
        .i_side (c_side),
        .o_valid(d1_vld),
        .o_quot (d1_hf),
        .o_side (d1_side_bits)
    );

    assign d1_side = t_side'(d1_side_bits);

    // ------------------------------------------------------------------
    // Back stage 1: row offsets, span test, display row
    // ------------------------------------------------------------------
    logic [HF_W-1:0]  base;
    logic [OFF_W-1:0] off_pos;
    logic [10:0]      off_neg;
    logic [11:0]      sr_wide;

    assign base = HF_W'(half) << FRAC_BITS;

    always_comb begin
        if (d1_hf > base) begin
            off_pos = OFF_W'((d1_hf - base) >> FRAC_BITS);
            off_neg = '0;
        end else begin
            off_pos = '0;
            off_neg = 11'((base - d1_hf) >> FRAC_BITS);
        end
    end

    assign sr_wide = 12'(d1_side.row) + 12'(off_neg);

    logic             r1_vld;
    logic [SUM_W-1:0] r1_sum;
    logic [10:0]      r1_sr;
    logic             r1_inside;
    logic [HF_W-1:0]  r1_hf;
    t_side            r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= d1_vld;
        end
        r1_sum    <= SUM_W'(d1_side.row) + SUM_W'(off_pos);
        r1_sr     <= (sr_wide > 12'(ROW_MAX)) ? ROW_MAX : sr_wide[10:0];
        r1_inside <= (d1_hf != '0)
                     && ((D2_W'(d1_side.row) << FRAC_BITS) < {d1_hf, 1'b0})
                     && (12'(d1_side.row) < r_screen_height);
        r1_hf     <= d1_hf;
        r1_side   <= d1_side;
    end

    // ------------------------------------------------------------------
    // Back stage 2: (row + offset) * texture height
    // ------------------------------------------------------------------
    logic               r2_vld;
    logic [PROD2_W-1:0] r2_prod;
    logic [HF_W-1:0]    r2_hf;
    logic [10:0]        r2_sr;
    logic               r2_inside;
    t_side              r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_prod   <= PROD2_W'(r1_sum) * PROD2_W'(r_texture_height);
        r2_hf     <= r1_hf;
        r2_sr     <= r1_sr;
        r2_inside <= r1_inside;
        r2_side   <= r1_side;
    end

    // ------------------------------------------------------------------
    // Texel row: (product << F) / (2 * height), quotient limited to 10 bits
    // with an overflow flag that forces saturation.
    // ------------------------------------------------------------------
    logic [N2_W-1:0] num2;
    logic [D2_W-1:0] den2;
    t_side2          side2;

    assign num2 = N2_W'(r2_prod) << FRAC_BITS;
    assign den2 = {r2_hf, 1'b0};

    always_comb begin
        side2.s       = r2_side;
        side2.in_span = r2_inside;
        side2.hfz     = r2_hf == '0;
        side2.ovf     = (num2 >> TR_Q_W) >= N2_W'(den2);
        side2.sr      = r2_sr;
    end

    logic                      d2_vld;
    logic [TR_Q_W-1:0]         d2_quot;
    logic [$bits(t_side2)-1:0] d2_side_bits;
    t_side2                    d2_side;

    rwtm_div_pipe #(
        .N_W(N2_W),
        .D_W(D2_W),
        .Q_W(TR_Q_W),
        .S_W($bits(t_side2))
    ) u_div_texrow (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r2_vld),
        .i_num  (num2),
        .i_den  (den2),
        .i_side (side2),
        .o_valid(d2_vld),
        .o_quot (d2_quot),
        .o_side (d2_side_bits)
    );

    assign d2_side = t_side2'(d2_side_bits);

    // ------------------------------------------------------------------
    // Output stage: texel row saturation, invalid-face zeroing
    // ------------------------------------------------------------------
    logic [9:0]  tr_q;
    logic [10:0] tr_lim;
    logic [9:0]  tr;

    assign tr_q   = d2_side.ovf ? TEXEL_MAX : d2_quot;
    assign tr_lim = r_texture_height - 11'd1;

    always_comb begin
        if (d2_side.hfz || r_texture_height == '0) begin
            tr = '0;
        end else if ({1'b0, tr_q} > tr_lim) begin
            tr = tr_lim[9:0];
        end else begin
            tr = tr_q;
        end
    end

    logic        r_out_vld;
    logic        r_in_column;
    logic [2:0]  r_texture_select;
    logic [9:0]  r_texel_column;
    logic [9:0]  r_texel_row;
    logic [10:0] r_screen_row;
    logic [11:0] r_dest_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= d2_vld;
        end
        r_dest_column <= d2_side.s.col;
        if (d2_side.s.fv) begin
            r_in_column      <= d2_side.in_span;
            r_texture_select <= d2_side.s.sel;
            r_texel_column   <= d2_side.s.tc;
            r_texel_row      <= tr;
            r_screen_row     <= d2_side.sr;
        end else begin
            r_in_column      <= 1'b0;
            r_texture_select <= '0;
            r_texel_column   <= '0;
            r_texel_row      <= '0;
            r_screen_row     <= '0;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_in_column      = r_in_column;
    assign o_texture_select = r_texture_select;
    assign o_texel_column   = r_texel_column;
    assign o_texel_row      = r_texel_row;
    assign o_screen_row     = r_screen_row;
    assign o_dest_column    = r_dest_column;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A reset leaves no result on the output in the following cycle.
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // The texture select never goes beyond the door texture.
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_texture_select <= TEX_DOOR)
        else $error("texture select out of range");

    // A span row needs a nonzero wall height.
    a_texrow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d2_vld && d2_side.hfz |-> !d2_side.in_span)
        else $error("row inside a span of zero height");

endmodule

`default_nettype wire

@@ tb/sv/raycast_wall_texel_mapper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_wall_texel_mapper_tb: self-checking bench for the wall texel mapper
// Drives pixels with bursty random timing, predicts each result with an
// independent fixed-point model of the fisheye correction and texel mapping,
// and checks every o_valid result in order against the predictions.
// ----------------------------------------------------------------------------

// Expected result of one pixel.
typedef struct packed {
    logic        in_col;
    logic [2:0]  tex_sel;
    logic [9:0]  tex_col;
    logic [9:0]  tex_row;
    logic [10:0] scr_row;
    logic [11:0] dst_col;
} texel_result_t;

class texel_scoreboard;
    texel_result_t pending[$];
    int            errors;
    logic [63:0]   cos_rom[1024];
    logic [11:0]   scr_h;
    logic [10:0]   tex_w;
    logic [10:0]   tex_h;

    function new();
        errors = 0;
        scr_h  = rwtm_pkg::RST_SCREEN_HEIGHT;
        tex_w  = rwtm_pkg::RST_TEXTURE_WIDTH;
        tex_h  = rwtm_pkg::RST_TEXTURE_HEIGHT;
        for (int k = 0; k < 1024; k++) cos_rom[k] = cosine_q16(k);
    endfunction

    // Signed Q16 cosine of k/1024 of a turn, from a Q30 Taylor series.
    function logic [63:0] cosine_q16(int k);
        logic [63:0] th, t2, term, mag;
        longint      acc;
        bit          neg;
        th  = 64'(k) * rwtm_pkg::TWO_PI_Q30 / 64'd1024;
        neg = 0;
        if (th > rwtm_pkg::PI_Q30) th = rwtm_pkg::TWO_PI_Q30 - th;
        if (th > rwtm_pkg::HALF_PI_Q30) begin
            th  = rwtm_pkg::PI_Q30 - th;
            neg = 1;
        end
        t2   = (th * th) >> 30;
        term = rwtm_pkg::ONE_Q30;
        acc  = longint'(term);
        for (int i = 1; i <= 7; i++) begin
            term = ((term * t2) >> 30) / 64'((2 * i - 1) * (2 * i));
            if (i % 2) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        mag = (64'(acc) + 64'd8192) >> 14;
        return neg ? -mag : mag;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            rwtm_pkg::REG_SCREEN_HEIGHT:  scr_h = val[11:0];
            rwtm_pkg::REG_TEXTURE_WIDTH:  tex_w = val[10:0];
            rwtm_pkg::REG_TEXTURE_HEIGHT: tex_h = val[10:0];
            default: ;
        endcase
    endfunction

    // Note an accepted pixel and queue the result it must produce.
    function void note_pixel(logic [15:0] ra, logic [15:0] pa, logic [23:0] rdist,
                             logic [23:0] hx, logic [23:0] hy, logic [2:0] face,
                             logic [11:0] col, logic [10:0] row);
        texel_result_t r;
        logic [63:0] idx, adj, half, hf, base, opos, oneg, coord, tc, tr, sr;
        longint      c;
        r = '0;
        r.dst_col = col;
        if (face <= rwtm_pkg::FACE_DOOR_EW) begin
            idx = (64'(16'(ra - pa)) * 64'd1024) >> 16;
            c   = longint'(cos_rom[idx]);
            if (c <= 0) adj = 64'd6554;
            else begin
                adj = (64'(rdist) * 64'(c)) >> 16;
                if (adj < 64'd6554) adj = 64'd6554;
            end
            half = 64'(scr_h) >> 1;
            hf   = (half << 32) / adj;
            base = half << 16;
            opos = 0;
            oneg = 0;
            if (hf > base) opos = (hf - base) >> 16;
            else oneg = (base - hf) >> 16;
            r.in_col = hf > 0 && (64'(row) << 16) < 2 * hf && 12'(row) < scr_h;
            coord = (face == rwtm_pkg::FACE_NORTH || face == rwtm_pkg::FACE_SOUTH
                     || face == rwtm_pkg::FACE_DOOR_NS) ? 64'(hx) : 64'(hy);
            r.tex_sel = face > rwtm_pkg::TEX_DOOR ? rwtm_pkg::TEX_DOOR : face;
            tc = ((coord & 64'hFFFF) * 64'(tex_w)) >> 16;
            r.tex_col = tc > 1023 ? rwtm_pkg::TEXEL_MAX : tc[9:0];
            if (hf == 0 || tex_h == 0) tr = 0;
            else begin
                tr = (((64'(row) + opos) * 64'(tex_h)) << 16) / (2 * hf);
                if (tr > 64'(tex_h) - 1) tr = 64'(tex_h) - 1;
                if (tr > 1023) tr = 1023;
            end
            r.tex_row = tr[9:0];
            sr = 64'(row) + oneg;
            r.scr_row = sr > 2047 ? rwtm_pkg::ROW_MAX : sr[10:0];
        end
        pending.push_back(r);
    endfunction

    // Compare one result against the oldest expectation.
    function void check_result(texel_result_t got);
        texel_result_t exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.in_col !== exp_r.in_col) begin
            $display("%0t: in_column exp %0d got %0d", $time, exp_r.in_col, got.in_col);
            errors++;
        end
        if (got.tex_sel !== exp_r.tex_sel) begin
            $display("%0t: texture_select exp %0d got %0d", $time, exp_r.tex_sel,
                     got.tex_sel);
            errors++;
        end
        if (got.tex_col !== exp_r.tex_col) begin
            $display("%0t: texel_column exp %0d got %0d", $time, exp_r.tex_col,
                     got.tex_col);
            errors++;
        end
        if (got.tex_row !== exp_r.tex_row) begin
            $display("%0t: texel_row exp %0d got %0d", $time, exp_r.tex_row, got.tex_row);
            errors++;
        end
        if (got.scr_row !== exp_r.scr_row) begin
            $display("%0t: screen_row exp %0d got %0d", $time, exp_r.scr_row, got.scr_row);
            errors++;
        end
        if (got.dst_col !== exp_r.dst_col) begin
            $display("%0t: dest_column exp %0d got %0d", $time, exp_r.dst_col, got.dst_col);
            errors++;
        end
    endfunction
endclass

module raycast_wall_texel_mapper_tb;
    import rwtm_pkg::*;

    localparam int LATENCY   = 48;
    localparam int MAX_CYCLE = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_ray_angle;
    logic [15:0] i_player_angle;
    logic [23:0] i_ray_distance;
    logic [23:0] i_hit_x;
    logic [23:0] i_hit_y;
    logic [2:0]  i_face;
    logic [11:0] i_screen_column;
    logic [10:0] i_row;
    logic        o_valid;
    logic        o_in_column;
    logic [2:0]  o_texture_select;
    logic [9:0]  o_texel_column;
    logic [9:0]  o_texel_row;
    logic [10:0] o_screen_row;
    logic [11:0] o_dest_column;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    texel_scoreboard sb;
    int              cycles = 0;
    int              burst_left;

    raycast_wall_texel_mapper u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_ray_angle     (i_ray_angle),
        .i_player_angle  (i_player_angle),
        .i_ray_distance  (i_ray_distance),
        .i_hit_x         (i_hit_x),
        .i_hit_y         (i_hit_y),
        .i_face          (i_face),
        .i_screen_column (i_screen_column),
        .i_row           (i_row),
        .o_valid         (o_valid),
        .o_in_column     (o_in_column),
        .o_texture_select(o_texture_select),
        .o_texel_column  (o_texel_column),
        .o_texel_row     (o_texel_row),
        .o_screen_row    (o_screen_row),
        .o_dest_column   (o_dest_column),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Results cannot be held off, so every strobe is checked at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result({o_in_column, o_texture_select, o_texel_column,
                             o_texel_row, o_screen_row, o_dest_column});
    end

    // Watchdog: a hung pipeline must not stall the run forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("FAIL");
            $finish;
        end
    end

    // Setup then access phase; the register lands at the access edge since pready is high.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Present one pixel and hold it until taken. Between items the sender
    // works in bursts, with random gaps in which start drops.
    task automatic send_pixel(logic [15:0] ra, logic [15:0] pa, logic [23:0] rdist,
                              logic [23:0] hx, logic [23:0] hy, logic [2:0] face,
                              logic [11:0] col, logic [10:0] row);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start           <= 1'b1;
        i_ray_angle     <= ra;
        i_player_angle  <= pa;
        i_ray_distance  <= rdist;
        i_hit_x         <= hx;
        i_hit_y         <= hy;
        i_face          <= face;
        i_screen_column <= col;
        i_row           <= row;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(ra, pa, rdist, hx, hy, face, col, row);
    endtask

    // Lower start, let the pipeline run dry, then allow its full latency.
    task automatic drain();
        int waited;
        start  <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (sb.pending.size() != 0 && waited < 10 * LATENCY + 100) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Random pixel: mostly believable distances and view-cone angles, the
    // rest anywhere in range.
    task automatic random_pixel(int max_row);
        logic [15:0] pa;
        logic [23:0] rdist;
        pa = 16'($urandom);
        case ($urandom_range(0, 3))
            0:       rdist = 24'($urandom);
            1:       rdist = 24'($urandom_range(0, 8000));
            default: rdist = 24'($urandom_range(6000, 24'h0FFFFF));
        endcase
        send_pixel($urandom_range(0, 3) == 0 ? 16'($urandom)
                                              : 16'(pa + $urandom_range(0, 12000) - 6000),
                   pa, rdist, 24'($urandom), 24'($urandom),
                   $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5)),
                   12'($urandom), 11'($urandom_range(0, max_row)));
    endtask

    initial begin
        sb              = new();
        burst_left      = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_ray_angle     = '0;
        i_player_angle  = '0;
        i_ray_distance  = '0;
        i_hit_x         = '0;
        i_hit_y         = '0;
        i_face          = FACE_NORTH;
        i_screen_column = '0;
        i_row           = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at reset settings: every face including the two
        // unused codes, zero distance (clamped), maximum distance, a ray at
        // right angles and behind (cosine not positive), row extremes.
        send_pixel(16'd0, 16'd0, 24'd65536, 24'h01_8000, 24'h02_4000, FACE_NORTH,
                   12'd0, 11'd0);
        send_pixel(16'd0, 16'd0, 24'd0, 24'hFFFFFF, 24'h0, FACE_SOUTH, 12'd4095, 11'd2047);
        send_pixel(16'hFFFF, 16'd0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, FACE_EAST,
                   12'd100, 11'd239);
        send_pixel(16'd16384, 16'd0, 24'd65536, 24'h00FFFF, 24'h000001, FACE_WEST,
                   12'd1, 11'd479);
        send_pixel(16'd0, 16'd32768, 24'd131072, 24'h123456, 24'h654321, FACE_DOOR_NS,
                   12'd2, 11'd480);
        send_pixel(16'd1000, 16'd65000, 24'd6553, 24'h000000, 24'h00FFFF, FACE_DOOR_EW,
                   12'd3, 11'd5);
        send_pixel(16'd0, 16'd0, 24'd65536, 24'hFFFFFF, 24'hFFFFFF, 3'd6, 12'd7, 11'd3);
        send_pixel(16'hFFFF, 16'hFFFF, 24'd65536, 24'hFFFFFF, 24'hFFFFFF, 3'd7,
                   12'd8, 11'd2047);
        send_pixel(16'd5000, 16'd0, 24'd3000000, 24'h00AAAA, 24'h005555, FACE_NORTH,
                   12'd9, 11'd1);
        drain();

        // Settings sweep: reset values, extremes (including zero heights and
        // widths outside the nominal range), and random ones.
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(REG_SCREEN_HEIGHT, 32'd4095);
                    write_reg(REG_TEXTURE_WIDTH, 32'd2047);
                    write_reg(REG_TEXTURE_HEIGHT, 32'd2047);
                end
                2: begin
                    write_reg(REG_SCREEN_HEIGHT, 32'd1);
                    write_reg(REG_TEXTURE_WIDTH, 32'd1);
                    write_reg(REG_TEXTURE_HEIGHT, 32'd1);
                end
                3: begin
                    write_reg(REG_SCREEN_HEIGHT, 32'd0);
                    write_reg(REG_TEXTURE_WIDTH, 32'd0);
                    write_reg(REG_TEXTURE_HEIGHT, 32'd0);
                end
                4: begin
                    write_reg(REG_SCREEN_HEIGHT, 32'd2048);
                    write_reg(REG_TEXTURE_WIDTH, 32'd1024);
                    write_reg(REG_TEXTURE_HEIGHT, 32'd1024);
                end
                default: begin
                    write_reg(REG_SCREEN_HEIGHT, 32'($urandom));
                    write_reg(REG_TEXTURE_WIDTH, 32'($urandom));
                    write_reg(REG_TEXTURE_HEIGHT, 32'($urandom));
                end
            endcase
            for (int n = 0; n < 85; n++)
                random_pixel(n % 4 == 0 ? 2047 : int'(sb.scr_h) + 16);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
